// ===== rtl/byte_mode_alu_with_flags_unit_assert.svh =====
// Assertion macros for the byte ALU checker.
`ifndef BYTE_MODE_ALU_WITH_FLAGS_UNIT_ASSERT_SVH
`define BYTE_MODE_ALU_WITH_FLAGS_UNIT_ASSERT_SVH

// Check a property outside reset.
`define BMA_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("byte alu assertion failed");

// Check a property at every edge, reset included.
`define BMA_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("byte alu assertion failed");

`endif

// ===== rtl/bma_pkg.sv =====
package bma_pkg;

  typedef enum logic [3:0] {
    OP_RRC,
    OP_RRA,
    OP_PUSH,
    OP_MOV,
    OP_ADD,
    OP_ADDC,
    OP_SUBC,
    OP_SUB,
    OP_CMP,
    OP_NOP,
    OP_BIT,
    OP_BIC,
    OP_BIS,
    OP_XOR,
    OP_AND,
    OP_ERR
  } alu_op_t;

  localparam logic FMT_SINGLE = 1'b0;

  localparam logic [2:0] SEL1_RRC  = 3'd0;
  localparam logic [2:0] SEL1_RRA  = 3'd2;
  localparam logic [2:0] SEL1_PUSH = 3'd4;

  localparam logic [3:0] SEL2_MOV  = 4'd4;
  localparam logic [3:0] SEL2_ADD  = 4'd5;
  localparam logic [3:0] SEL2_ADDC = 4'd6;
  localparam logic [3:0] SEL2_SUBC = 4'd7;
  localparam logic [3:0] SEL2_SUB  = 4'd8;
  localparam logic [3:0] SEL2_CMP  = 4'd9;
  localparam logic [3:0] SEL2_DADD = 4'd10;
  localparam logic [3:0] SEL2_BIT  = 4'd11;
  localparam logic [3:0] SEL2_BIC  = 4'd12;
  localparam logic [3:0] SEL2_BIS  = 4'd13;
  localparam logic [3:0] SEL2_XOR  = 4'd14;
  localparam logic [3:0] SEL2_AND  = 4'd15;

  localparam int SR_C = 0;
  localparam int SR_Z = 1;
  localparam int SR_N = 2;
  localparam int SR_V = 8;

  localparam logic [15:0] SP_STEP = 16'd2;

  typedef struct packed {
    alu_op_t     op;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [15:0] sp;
    logic [15:0] status;
  } item_t;

  typedef struct packed {
    logic        write_dest;
    logic [7:0]  dest_value;
    logic        push_valid;
    logic [15:0] push_address;
    logic [7:0]  push_data;
    logic [15:0] status_out;
    logic        error;
  } result_t;

  function automatic logic [15:0] flags_word(logic c, logic z, logic n, logic v);
    logic [15:0] w;
    w = '0;
    w[SR_C] = c;
    w[SR_Z] = z;
    w[SR_N] = n;
    w[SR_V] = v;
    return w;
  endfunction

endpackage

// ===== rtl/bma_channels.sv =====
interface bma_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] opcode;
  logic [7:0]  src_byte;
  logic [7:0]  dst_byte;
  logic [15:0] stack_pointer;
  logic [15:0] status_in;

  modport source (output valid, command, opcode, src_byte, dst_byte, stack_pointer,
                  status_in, input ready);
  modport sink (input valid, command, opcode, src_byte, dst_byte, stack_pointer,
                status_in, output ready);
endinterface

interface bma_out_if;
  logic        valid;
  logic        ready;
  logic        write_dest;
  logic [7:0]  dest_value;
  logic        push_valid;
  logic [15:0] push_address;
  logic [7:0]  push_data;
  logic [15:0] status_out;
  logic        error;

  modport source (output valid, write_dest, dest_value, push_valid, push_address,
                  push_data, status_out, error, input ready);
  modport sink (input valid, write_dest, dest_value, push_valid, push_address,
                push_data, status_out, error, output ready);
endinterface

// ===== rtl/bma_front.sv =====
module bma_front (
  input  logic             clk,
  input  logic             rst,
  bma_in_if.sink           instr,
  output logic             q_valid,
  input  logic             q_ready,
  output bma_pkg::item_t   q_item
);

  logic             vld;
  bma_pkg::item_t   item;
  bma_pkg::alu_op_t op_dec;
  logic [2:0]       sel1;
  logic [3:0]       sel2;

  assign sel1 = instr.opcode[9:7];
  assign sel2 = instr.opcode[15:12];

  always_comb begin
    op_dec = bma_pkg::OP_ERR;
    if (instr.command == bma_pkg::FMT_SINGLE) begin
      unique case (sel1)
        bma_pkg::SEL1_RRC:  op_dec = bma_pkg::OP_RRC;
        bma_pkg::SEL1_RRA:  op_dec = bma_pkg::OP_RRA;
        bma_pkg::SEL1_PUSH: op_dec = bma_pkg::OP_PUSH;
        default:            op_dec = bma_pkg::OP_ERR;
      endcase
    end else begin
      unique case (sel2)
        bma_pkg::SEL2_MOV:  op_dec = bma_pkg::OP_MOV;
        bma_pkg::SEL2_ADD:  op_dec = bma_pkg::OP_ADD;
        bma_pkg::SEL2_ADDC: op_dec = bma_pkg::OP_ADDC;
        bma_pkg::SEL2_SUBC: op_dec = bma_pkg::OP_SUBC;
        bma_pkg::SEL2_SUB:  op_dec = bma_pkg::OP_SUB;
        bma_pkg::SEL2_CMP:  op_dec = bma_pkg::OP_CMP;
        bma_pkg::SEL2_DADD: op_dec = bma_pkg::OP_NOP;
        bma_pkg::SEL2_BIT:  op_dec = bma_pkg::OP_BIT;
        bma_pkg::SEL2_BIC:  op_dec = bma_pkg::OP_BIC;
        bma_pkg::SEL2_BIS:  op_dec = bma_pkg::OP_BIS;
        bma_pkg::SEL2_XOR:  op_dec = bma_pkg::OP_XOR;
        bma_pkg::SEL2_AND:  op_dec = bma_pkg::OP_AND;
        default:            op_dec = bma_pkg::OP_ERR;
      endcase
    end
  end

  // take a new item whenever the stage is empty or draining
  assign instr.ready = !vld || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (instr.ready) begin
      vld <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (instr.valid && instr.ready) begin
      item.op     <= op_dec;
      item.src    <= instr.src_byte;
      item.dst    <= instr.dst_byte;
      item.sp     <= instr.stack_pointer;
      item.status <= instr.status_in;
    end
  end

  assign q_valid = vld;
  assign q_item  = item;

endmodule

// ===== rtl/bma_queue.sv =====
module bma_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  bma_pkg::item_t  push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output bma_pkg::item_t  pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  bma_pkg::item_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/bma_exec.sv =====
module bma_exec (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  bma_pkg::item_t  q_item,
  bma_out_if.source       result
);

  logic              ovld;
  bma_pkg::result_t  res;
  bma_pkg::result_t  res_next;
  logic              sub;
  logic              cin;
  logic              carry;
  logic [7:0]        s;
  logic [7:0]        d;
  logic [7:0]        b;
  logic [8:0]        sum;
  logic [7:0]        r_add;
  logic              v_add;
  logic [7:0]        r_and;
  logic [7:0]        r_xor;
  logic [7:0]        r_rot;

  assign s     = q_item.src;
  assign d     = q_item.dst;
  assign carry = q_item.status[bma_pkg::SR_C];

  assign sub = (q_item.op == bma_pkg::OP_SUBC) || (q_item.op == bma_pkg::OP_SUB) ||
               (q_item.op == bma_pkg::OP_CMP);
  assign b   = sub ? ~s : s;

  always_comb begin
    case (q_item.op)
      bma_pkg::OP_ADDC, bma_pkg::OP_SUBC: cin = carry;
      bma_pkg::OP_SUB, bma_pkg::OP_CMP:   cin = 1'b1;
      default:                            cin = 1'b0;
    endcase
  end

  assign sum   = {1'b0, d} + {1'b0, b} + {8'd0, cin};
  assign r_add = sum[7:0];
  assign v_add = (d[7] ^ r_add[7]) & (b[7] ^ r_add[7]);
  assign r_and = d & s;
  assign r_xor = d ^ s;
  // rrc shifts the carry in, rra keeps the sign
  assign r_rot = {(q_item.op == bma_pkg::OP_RRC) ? carry : s[7], s[7:1]};

  always_comb begin
    res_next              = '0;
    res_next.status_out   = q_item.status;
    case (q_item.op)
      bma_pkg::OP_RRC, bma_pkg::OP_RRA: begin
        res_next.write_dest = 1'b1;
        res_next.dest_value = r_rot;
        res_next.status_out = bma_pkg::flags_word(s[0], r_rot == 8'd0, r_rot[7], 1'b0);
      end
      bma_pkg::OP_PUSH: begin
        res_next.push_valid   = 1'b1;
        res_next.push_address = q_item.sp - bma_pkg::SP_STEP;
        res_next.push_data    = s;
      end
      bma_pkg::OP_MOV: begin
        res_next.write_dest = 1'b1;
        res_next.dest_value = s;
      end
      bma_pkg::OP_ADD, bma_pkg::OP_ADDC, bma_pkg::OP_SUBC, bma_pkg::OP_SUB: begin
        res_next.write_dest = 1'b1;
        res_next.dest_value = r_add;
        res_next.status_out = bma_pkg::flags_word(sum[8], r_add == 8'd0, r_add[7], v_add);
      end
      bma_pkg::OP_CMP: begin
        res_next.status_out = bma_pkg::flags_word(sum[8], r_add == 8'd0, r_add[7], v_add);
      end
      bma_pkg::OP_BIT: begin
        res_next.status_out = bma_pkg::flags_word(r_and != 8'd0, r_and == 8'd0, r_and[7],
                                                  1'b0);
      end
      bma_pkg::OP_BIC: begin
        res_next.write_dest = 1'b1;
        res_next.dest_value = d & ~s;
      end
      bma_pkg::OP_BIS: begin
        res_next.write_dest = 1'b1;
        res_next.dest_value = d | s;
      end
      bma_pkg::OP_XOR: begin
        res_next.write_dest = 1'b1;
        res_next.dest_value = r_xor;
        res_next.status_out = bma_pkg::flags_word(r_xor != 8'd0, r_xor == 8'd0, r_xor[7],
                                                  d[7] & s[7]);
      end
      bma_pkg::OP_AND: begin
        res_next.write_dest = 1'b1;
        res_next.dest_value = r_and;
        res_next.status_out = bma_pkg::flags_word(r_and != 8'd0, r_and == 8'd0, r_and[7],
                                                  1'b0);
      end
      bma_pkg::OP_ERR: begin
        res_next.error = 1'b1;
      end
      default: begin
        res_next.error = 1'b0;
      end
    endcase
  end

  // advance when the output register is empty or being taken
  assign q_ready = !ovld || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovld <= 1'b0;
    end else if (q_ready) begin
      ovld <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      res <= res_next;
    end
  end

  assign result.valid        = ovld;
  assign result.write_dest   = res.write_dest;
  assign result.dest_value   = res.dest_value;
  assign result.push_valid   = res.push_valid;
  assign result.push_address = res.push_address;
  assign result.push_data    = res.push_data;
  assign result.status_out   = res.status_out;
  assign result.error        = res.error;

endmodule

// ===== rtl/byte_mode_alu_with_flags_unit.sv =====
// Byte-mode ALU with N/Z/C/V flags for a 16-bit microcontroller execute stage.
//
// instr (sink): one item per instruction: format bit, raw instruction word,
// source and destination bytes, stack pointer and status word.
// result (source): exactly one item per instruction: destination write,
// stack push, new status word and an error flag for undefined opcodes.
// Both channels move an item on a rising edge with valid and ready high.
//
// A front stage registers the item with its decoded operation, a queue of
// QUEUE_DEPTH entries follows, and the back stage runs the 8-bit add and flag
// logic into an output register. An item accepted from instr passes through the
// front register, the queue and the output register before it can be taken from
// result; one item per cycle is sustained while result.ready stays high.
//
// Reset empties all three stages; no result is shown afterwards until a new
// item arrives. When the receiver holds ready low the output register holds
// its item, the queue fills, and instr.ready drops once front and queue are
// full; nothing is dropped.
module byte_mode_alu_with_flags_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  bma_in_if.sink    instr,
  bma_out_if.source result
);

  logic             f_valid;
  logic             f_ready;
  bma_pkg::item_t   f_item;
  logic             b_valid;
  logic             b_ready;
  bma_pkg::item_t   b_item;

  bma_front u_front (
    .clk     (clk),
    .rst     (rst),
    .instr   (instr),
    .q_valid (f_valid),
    .q_ready (f_ready),
    .q_item  (f_item)
  );

  bma_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  bma_exec u_exec (
    .clk     (clk),
    .rst     (rst),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .q_item  (b_item),
    .result  (result)
  );

endmodule

// ===== rtl/bma_checker.sv =====
`include "byte_mode_alu_with_flags_unit_assert.svh"

module bma_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        write_dest,
  input logic [7:0]  dest_value,
  input logic        push_valid,
  input logic [15:0] push_address,
  input logic [7:0]  push_data,
  input logic [15:0] status_out,
  input logic        error
);

  logic [50:0] res_bits;

  assign res_bits = {write_dest, dest_value, push_valid, push_address, push_data, status_out,
                     error};

  // an undefined opcode writes nothing and pushes nothing
  `BMA_ASSERT(a_error_quiet, clk, rst, res_valid && error |-> !write_dest && !push_valid)

  // a push never writes the destination byte
  `BMA_ASSERT(a_push_excl, clk, rst, res_valid && push_valid |-> !write_dest && !error)

  // a stalled result holds
  `BMA_ASSERT(a_stall_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_bits))

  // reset empties the output
  `BMA_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !res_valid)

endmodule

bind byte_mode_alu_with_flags_unit bma_checker u_bma_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .write_dest   (result.write_dest),
  .dest_value   (result.dest_value),
  .push_valid   (result.push_valid),
  .push_address (result.push_address),
  .push_data    (result.push_data),
  .status_out   (result.status_out),
  .error        (result.error)
);

// ===== test/byte_mode_alu_with_flags_unit_test.sv =====
`timescale 1ns / 1ps

module byte_mode_alu_with_flags_unit_test;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 60;

  class alu_result_ledger;
    bma_pkg::result_t pending_results[$];
    int mismatches = 0;
    int checked = 0;
    int singles = 0;
    int pushes = 0;
    int undefined = 0;

    function logic [15:0] flag_word(input logic c, input logic [7:0] r, input logic v);
      logic [15:0] w;
      w = 16'h0000;
      w[bma_pkg::SR_C] = c;
      w[bma_pkg::SR_Z] = (r == 8'h00);
      w[bma_pkg::SR_N] = r[7];
      w[bma_pkg::SR_V] = v;
      return w;
    endfunction

    function logic [15:0] sum_flags(input logic [7:0] a, input logic [7:0] b,
                                    input logic cin, output logic [7:0] r);
      logic [8:0] sum;
      logic v;
      sum = {1'b0, a} + {1'b0, b} + {8'd0, cin};
      r = sum[7:0];
      // overflow when both addends disagree in sign with the sum
      v = (a[7] ^ r[7]) & (b[7] ^ r[7]);
      return flag_word(sum[8], r, v);
    endfunction

    function bma_pkg::result_t alu_outcome(input logic cmd, input logic [15:0] op,
                                           input logic [7:0] src, input logic [7:0] dst,
                                           input logic [15:0] sp, input logic [15:0] st);
      bma_pkg::result_t res;
      logic [7:0] r;
      logic cin;
      logic wr;
      res = '0;
      res.status_out = st;
      cin = st[bma_pkg::SR_C];
      r = 8'h00;
      wr = 1'b0;
      if (cmd == bma_pkg::FMT_SINGLE) begin
        case (op[9:7])
          bma_pkg::SEL1_RRC: begin
            r = {cin, src[7:1]};
            res.status_out = flag_word(src[0], r, 1'b0);
            wr = 1'b1;
          end
          bma_pkg::SEL1_RRA: begin
            r = {src[7], src[7:1]};
            res.status_out = flag_word(src[0], r, 1'b0);
            wr = 1'b1;
          end
          bma_pkg::SEL1_PUSH: begin
            res.push_valid = 1'b1;
            res.push_address = sp - bma_pkg::SP_STEP;
            res.push_data = src;
          end
          default: res.error = 1'b1;
        endcase
      end else begin
        case (op[15:12])
          bma_pkg::SEL2_MOV: begin
            r = src;
            wr = 1'b1;
          end
          bma_pkg::SEL2_ADD: begin
            res.status_out = sum_flags(dst, src, 1'b0, r);
            wr = 1'b1;
          end
          bma_pkg::SEL2_ADDC: begin
            res.status_out = sum_flags(dst, src, cin, r);
            wr = 1'b1;
          end
          bma_pkg::SEL2_SUBC: begin
            res.status_out = sum_flags(dst, ~src, cin, r);
            wr = 1'b1;
          end
          bma_pkg::SEL2_SUB: begin
            res.status_out = sum_flags(dst, ~src, 1'b1, r);
            wr = 1'b1;
          end
          bma_pkg::SEL2_CMP: res.status_out = sum_flags(dst, ~src, 1'b1, r);
          bma_pkg::SEL2_DADD: ;
          bma_pkg::SEL2_BIT:
            res.status_out = flag_word((dst & src) != 8'h00, dst & src, 1'b0);
          bma_pkg::SEL2_BIC: begin
            r = dst & ~src;
            wr = 1'b1;
          end
          bma_pkg::SEL2_BIS: begin
            r = dst | src;
            wr = 1'b1;
          end
          bma_pkg::SEL2_XOR: begin
            r = dst ^ src;
            res.status_out = flag_word(r != 8'h00, r, dst[7] & src[7]);
            wr = 1'b1;
          end
          bma_pkg::SEL2_AND: begin
            r = dst & src;
            res.status_out = flag_word(r != 8'h00, r, 1'b0);
            wr = 1'b1;
          end
          default: res.error = 1'b1;
        endcase
      end
      if (wr) begin
        res.write_dest = 1'b1;
        res.dest_value = r;
      end
      return res;
    endfunction

    function void note_instruction(input logic cmd, input logic [15:0] op,
                                   input logic [7:0] src, input logic [7:0] dst,
                                   input logic [15:0] sp, input logic [15:0] st);
      bma_pkg::result_t res;
      res = alu_outcome(cmd, op, src, dst, sp, st);
      pending_results.push_back(res);
      if (cmd == bma_pkg::FMT_SINGLE) singles++;
      if (res.push_valid) pushes++;
      if (res.error) undefined++;
    endfunction

    function void check_result(input bma_pkg::result_t got);
      bma_pkg::result_t want;
      logic bad;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with no instruction outstanding: %p", got);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      bad = (got.write_dest !== want.write_dest) || (got.dest_value !== want.dest_value) ||
            (got.push_valid !== want.push_valid) ||
            (got.push_address !== want.push_address) ||
            (got.push_data !== want.push_data) || (got.status_out !== want.status_out) ||
            (got.error !== want.error);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d expected: wr=%b val=%h push=%b addr=%h data=%h sr=%h err=%b",
                   checked, want.write_dest, want.dest_value, want.push_valid,
                   want.push_address, want.push_data, want.status_out, want.error);
          $display("result %0d actual:   wr=%b val=%h push=%b addr=%h data=%h sr=%h err=%b",
                   checked, got.write_dest, got.dest_value, got.push_valid,
                   got.push_address, got.push_data, got.status_out, got.error);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int cycle_count = 0;
  int hold_cycles = 0;
  bit sender_gaps = 1'b0;
  bit receiver_gaps = 1'b0;
  alu_result_ledger ledger = new();

  bma_in_if instr_ch ();
  bma_out_if result_ch ();

  byte_mode_alu_with_flags_unit uut (
    .clk(clk),
    .rst(rst),
    .instr(instr_ch),
    .result(result_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_operand();
    logic [7:0] corners[5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(0, 99) < 30) return corners[$urandom_range(0, 4)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] single_word(input logic [2:0] sel, input logic [15:0] noise);
    logic [15:0] w;
    w = noise;
    w[9:7] = sel;
    return w;
  endfunction

  function automatic logic [15:0] dual_word(input logic [3:0] sel, input logic [15:0] noise);
    logic [15:0] w;
    w = noise;
    w[15:12] = sel;
    return w;
  endfunction

  // note each accepted instruction and check each accepted result
  always @(posedge clk) begin
    if (!rst && instr_ch.valid && instr_ch.ready)
      ledger.note_instruction(instr_ch.command, instr_ch.opcode, instr_ch.src_byte,
                              instr_ch.dst_byte, instr_ch.stack_pointer, instr_ch.status_in);
    if (!rst && result_ch.valid && result_ch.ready)
      ledger.check_result('{write_dest: result_ch.write_dest,
                            dest_value: result_ch.dest_value,
                            push_valid: result_ch.push_valid,
                            push_address: result_ch.push_address,
                            push_data: result_ch.push_data,
                            status_out: result_ch.status_out,
                            error: result_ch.error});
  end

  // result receiver: one assignment to ready per edge
  initial begin
    int gap_left;
    gap_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        result_ch.ready <= 1'b0;
        hold_cycles--;
      end else if (gap_left > 0) begin
        result_ch.ready <= 1'b0;
        gap_left--;
      end else begin
        result_ch.ready <= 1'b1;
        if (receiver_gaps && $urandom_range(0, 99) < 25) gap_left = pick_gap();
      end
    end
  end

  task automatic send_instruction(input logic cmd, input logic [15:0] op,
                                  input logic [7:0] src, input logic [7:0] dst,
                                  input logic [15:0] sp, input logic [15:0] st);
    int gap;
    instr_ch.valid <= 1'b1;
    instr_ch.command <= cmd;
    instr_ch.opcode <= op;
    instr_ch.src_byte <= src;
    instr_ch.dst_byte <= dst;
    instr_ch.stack_pointer <= sp;
    instr_ch.status_in <= st;
    @(posedge clk);
    while (!instr_ch.ready) @(posedge clk);
    if (sender_gaps && $urandom_range(0, 99) < 25) begin
      gap = pick_gap();
      instr_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_instruction();
    logic cmd;
    logic [15:0] op;
    logic [15:0] sp;
    cmd = ($urandom_range(0, 99) < 30) ? bma_pkg::FMT_SINGLE : ~bma_pkg::FMT_SINGLE;
    op = 16'($urandom_range(0, 65535));
    if (cmd != bma_pkg::FMT_SINGLE)
      op = dual_word(($urandom_range(0, 99) < 10) ? 4'($urandom_range(0, 3))
                                                  : 4'($urandom_range(4, 15)), op);
    sp = ($urandom_range(0, 99) < 5) ? 16'($urandom_range(0, 1)) : 16'($urandom_range(0, 65535));
    send_instruction(cmd, op, pick_operand(), pick_operand(), sp,
                     16'($urandom_range(0, 65535)));
  endtask

  // drop valid, switch idling between edges, resume on a rising edge
  task automatic set_idling(input bit on_send, input bit on_receive);
    instr_ch.valid <= 1'b0;
    @(negedge clk);
    sender_gaps = on_send;
    receiver_gaps = on_receive;
    @(posedge clk);
  endtask

  task automatic drain_results();
    instr_ch.valid <= 1'b0;
    while (ledger.pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    instr_ch.valid <= 1'b0;
    instr_ch.command <= bma_pkg::FMT_SINGLE;
    instr_ch.opcode <= 16'h0000;
    instr_ch.src_byte <= 8'h00;
    instr_ch.dst_byte <= 8'h00;
    instr_ch.stack_pointer <= 16'h0000;
    instr_ch.status_in <= 16'h0000;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // rotates, pushes with stack wrap, and ignored opcode bits
    send_instruction(bma_pkg::FMT_SINGLE, single_word(bma_pkg::SEL1_RRC, 16'h0000), 8'h01,
                     8'h00, 16'h1234, 16'h0001);
    send_instruction(bma_pkg::FMT_SINGLE, single_word(bma_pkg::SEL1_RRC, 16'hFFFF), 8'h00,
                     8'hFF, 16'hFFFF, 16'hFFFE);
    send_instruction(bma_pkg::FMT_SINGLE, single_word(bma_pkg::SEL1_RRA, 16'hFFFF), 8'h81,
                     8'h00, 16'h0000, 16'hFFFF);
    send_instruction(bma_pkg::FMT_SINGLE, single_word(bma_pkg::SEL1_PUSH, 16'h0000), 8'hFF,
                     8'h00, 16'h0000, 16'h0000);
    send_instruction(bma_pkg::FMT_SINGLE, single_word(bma_pkg::SEL1_PUSH, 16'hFFFF), 8'h00,
                     8'hFF, 16'h0001, 16'hFFFF);
    // undefined selectors in both formats
    send_instruction(bma_pkg::FMT_SINGLE, single_word(3'd1, 16'h0000), 8'hA5, 8'h5A,
                     16'h8000, 16'h0105);
    send_instruction(bma_pkg::FMT_SINGLE, single_word(3'd3, 16'hFFFF), 8'hFF, 8'hFF,
                     16'hFFFF, 16'hFFFF);
    send_instruction(bma_pkg::FMT_SINGLE, single_word(3'd7, 16'h5555), 8'h00, 8'h00,
                     16'h0000, 16'h0000);
    send_instruction(~bma_pkg::FMT_SINGLE, dual_word(4'd0, 16'h0FFF), 8'h12, 8'h34,
                     16'h0002, 16'h0107);
    send_instruction(~bma_pkg::FMT_SINGLE, dual_word(4'd3, 16'h0000), 8'hFF, 8'h00,
                     16'hFFFF, 16'hFEF8);
    // every two-operand operation on corner operands
    send_instruction(~bma_pkg::FMT_SINGLE, dual_word(bma_pkg::SEL2_MOV, 16'h0FFF), 8'h80,
                     8'h7F, 16'h0000, 16'hFFFF);
    send_instruction(~bma_pkg::FMT_SINGLE, dual_word(bma_pkg::SEL2_ADD, 16'h0000), 8'h01,
                     8'hFF, 16'h0000, 16'hFFFF);
    send_instruction(~bma_pkg::FMT_SINGLE, dual_word(bma_pkg::SEL2_ADD, 16'h0AAA), 8'h01,
                     8'h7F, 16'h0000, 16'h0000);
    send_instruction(~bma_pkg::FMT_SINGLE, dual_word(bma_pkg::SEL2_ADDC, 16'h0000), 8'hFF,
                     8'hFF, 16'h0000, 16'h0001);
    send_instruction(~bma_pkg::FMT_SINGLE, dual_word(bma_pkg::SEL2_SUBC, 16'h0FFF), 8'h01,
                     8'h00, 16'h0000, 16'h0000);
    send_instruction(~bma_pkg::FMT_SINGLE, dual_word(bma_pkg::SEL2_SUB, 16'h0000), 8'h01,
                     8'h80, 16'h0000, 16'h0000);
    send_instruction(~bma_pkg::FMT_SINGLE, dual_word(bma_pkg::SEL2_CMP, 16'h0000), 8'h5A,
                     8'h5A, 16'h0000, 16'hFEFF);
    send_instruction(~bma_pkg::FMT_SINGLE, dual_word(bma_pkg::SEL2_DADD, 16'h0FFF), 8'h99,
                     8'h99, 16'h0000, 16'h0107);
    send_instruction(~bma_pkg::FMT_SINGLE, dual_word(bma_pkg::SEL2_BIT, 16'h0000), 8'h80,
                     8'hFF, 16'h0000, 16'h0100);
    send_instruction(~bma_pkg::FMT_SINGLE, dual_word(bma_pkg::SEL2_BIC, 16'h0000), 8'hFF,
                     8'hFF, 16'h0000, 16'h0000);
    send_instruction(~bma_pkg::FMT_SINGLE, dual_word(bma_pkg::SEL2_BIS, 16'h0FFF), 8'h00,
                     8'h00, 16'h0000, 16'h0107);
    send_instruction(~bma_pkg::FMT_SINGLE, dual_word(bma_pkg::SEL2_XOR, 16'h0000), 8'h80,
                     8'h80, 16'h0000, 16'h0000);
    send_instruction(~bma_pkg::FMT_SINGLE, dual_word(bma_pkg::SEL2_AND, 16'h0000), 8'h55,
                     8'hAA, 16'h0000, 16'hFFFF);
    drain_results();

    set_idling(1'b1, 1'b1);
    repeat (500) send_random_instruction();

    // back-to-back on both sides
    set_idling(1'b0, 1'b0);
    repeat (300) send_random_instruction();

    // hold the receiver off while instructions keep coming, then pause the sender
    instr_ch.valid <= 1'b0;
    @(negedge clk);
    hold_cycles = HOLD_OFF_CYCLES;
    @(posedge clk);
    repeat (40) send_random_instruction();
    drain_results();

    set_idling(1'b1, 1'b1);
    repeat (910) send_random_instruction();
    drain_results();
    repeat (8) @(posedge clk);

    $display("covered %0d instructions: %0d single-operand, %0d pushes, %0d undefined",
             ledger.checked, ledger.singles, ledger.pushes, ledger.undefined);
    $display("idle gaps on both channels, back-to-back traffic and a %0d-cycle result hold-off",
             HOLD_OFF_CYCLES);
    if (ledger.mismatches == 0 && ledger.pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results never seen",
               ledger.mismatches, ledger.pending_results.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bma_pkg.sv
rtl/bma_channels.sv
rtl/bma_front.sv
rtl/bma_queue.sv
rtl/bma_exec.sv
rtl/byte_mode_alu_with_flags_unit.sv
rtl/bma_checker.sv
test/byte_mode_alu_with_flags_unit_test.sv
